>>> design/ethp_pkg.sv
package ethp_pkg;

    localparam int unsigned DATA_W     = 8;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned OFFSET_W   = 16;
    localparam int unsigned M_TDATA_W  = 224;
    localparam int unsigned RES_W      = 218;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W     = 2;
    localparam int unsigned QCNT_W     = 3;

    localparam logic [CFG_W-1:0]    MAX_SHOWN_RESET = 16'd200;
    localparam logic [15:0]         ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]          PROTO_TCP       = 8'd6;
    localparam logic [6:0]          ETH_HDR_LEN     = 7'd14;
    localparam logic [OFFSET_W-1:0] OFFSET_LIMIT    = 16'hFFFF;
    localparam logic [7:0]          CHAR_LOW        = 8'd32;
    localparam logic [7:0]          CHAR_HIGH       = 8'd126;
    localparam logic [7:0]          CHAR_DOT        = 8'd46;

    localparam logic                REG_MAX_SHOWN   = 1'b0;

    localparam logic                KIND_CHAR       = 1'b0;
    localparam logic                KIND_SUMMARY    = 1'b1;

    localparam logic [1:0]          CLASS_OTHER     = 2'd0;
    localparam logic [1:0]          CLASS_IPV4      = 2'd1;
    localparam logic [1:0]          CLASS_TCP       = 2'd2;

    typedef struct packed {
        logic [15:0] payload_len;
        logic [1:0]  frame_class;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [31:0] dst_ip;
        logic [31:0] src_ip;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [7:0]  text_char;
    } result_t;

    typedef struct packed {
        logic    kind;
        result_t res;
    } entry_t;

    typedef struct packed {
        logic [1:0] count;
    } push_t;

    typedef struct packed {
        logic not_empty;
        logic room2;
    } queue_status_t;

endpackage

>>> design/ethp_parser.sv
module ethp_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ethp_pkg::CFG_W-1:0]    max_shown,
    input  logic [ethp_pkg::DATA_W-1:0]   in_byte,
    input  logic                          in_end,
    input  logic                          in_fire,
    output ethp_pkg::push_t               push,
    output ethp_pkg::entry_t              first_item,
    output ethp_pkg::entry_t              second_item
);

    logic [15:0] off_reg;
    logic [47:0] dst_mac_reg, dst_mac_next;
    logic [47:0] src_mac_reg, src_mac_next;
    logic [15:0] ether_type_reg, ether_type_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [15:0] total_len_reg, total_len_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_ip_reg, src_ip_next;
    logic [31:0] dst_ip_reg, dst_ip_next;
    logic [15:0] src_port_reg, src_port_next;
    logic [15:0] dst_port_reg, dst_port_next;
    logic [3:0]  doff_reg, doff_next;
    logic [15:0] shown_reg, shown_next;

    logic        active;
    logic [6:0]  tcp_start;
    logic [15:0] tcp_rel;
    logic [7:0]  pay_start;
    logic [15:0] pay_rel;
    logic [6:0]  hdrs;
    logic [15:0] plen;
    logic [1:0]  cls;
    logic        show;
    logic [7:0]  shown_char;
    ethp_pkg::entry_t char_item;
    ethp_pkg::entry_t sum_item;

    assign active = (off_reg != ethp_pkg::OFFSET_LIMIT);

    always_comb begin
        dst_mac_next    = dst_mac_reg;
        src_mac_next    = src_mac_reg;
        ether_type_next = ether_type_reg;
        ihl_next        = ihl_reg;
        total_len_next  = total_len_reg;
        proto_next      = proto_reg;
        src_ip_next     = src_ip_reg;
        dst_ip_next     = dst_ip_reg;
        src_port_next   = src_port_reg;
        dst_port_next   = dst_port_reg;
        doff_next       = doff_reg;
        if (active) begin
            if (off_reg < 16'd6) begin
                dst_mac_next = {dst_mac_reg[39:0], in_byte};
            end else if (off_reg < 16'd12) begin
                src_mac_next = {src_mac_reg[39:0], in_byte};
            end else if (off_reg < 16'd14) begin
                ether_type_next = {ether_type_reg[7:0], in_byte};
            end
            if (off_reg == 16'd14) begin
                ihl_next = in_byte[3:0];
            end
            if (off_reg == 16'd16 || off_reg == 16'd17) begin
                total_len_next = {total_len_reg[7:0], in_byte};
            end
            if (off_reg == 16'd23) begin
                proto_next = in_byte;
            end
            if (off_reg >= 16'd26 && off_reg <= 16'd29) begin
                src_ip_next = {src_ip_reg[23:0], in_byte};
            end
            if (off_reg >= 16'd30 && off_reg <= 16'd33) begin
                dst_ip_next = {dst_ip_reg[23:0], in_byte};
            end
        end
        tcp_start = ethp_pkg::ETH_HDR_LEN + {1'b0, ihl_next, 2'b00};
        tcp_rel   = off_reg - {9'd0, tcp_start};
        if (active && off_reg >= {9'd0, tcp_start}) begin
            if (tcp_rel <= 16'd1) begin
                src_port_next = {src_port_reg[7:0], in_byte};
            end else if (tcp_rel <= 16'd3) begin
                dst_port_next = {dst_port_reg[7:0], in_byte};
            end else if (tcp_rel == 16'd12) begin
                doff_next = in_byte[7:4];
            end
        end
    end

    always_comb begin
        pay_start = {1'b0, tcp_start} + {2'b00, doff_next, 2'b00};
        pay_rel   = off_reg - {8'd0, pay_start};
        hdrs      = {1'b0, ihl_next, 2'b00} + {1'b0, doff_next, 2'b00};
        plen      = (total_len_next > {9'd0, hdrs}) ? (total_len_next - {9'd0, hdrs}) : 16'd0;
        if (ether_type_next != ethp_pkg::ETHERTYPE_IPV4) begin
            cls = ethp_pkg::CLASS_OTHER;
        end else if (proto_next == ethp_pkg::PROTO_TCP) begin
            cls = ethp_pkg::CLASS_TCP;
        end else begin
            cls = ethp_pkg::CLASS_IPV4;
        end
        show = active && (cls == ethp_pkg::CLASS_TCP) && (off_reg >= {8'd0, pay_start})
            && (pay_rel < plen) && (shown_reg < max_shown);
        shown_char = (in_byte >= ethp_pkg::CHAR_LOW && in_byte <= ethp_pkg::CHAR_HIGH)
            ? in_byte : ethp_pkg::CHAR_DOT;
        shown_next = show ? shown_reg + 16'd1 : shown_reg;
    end

    always_comb begin
        char_item               = '0;
        char_item.kind          = ethp_pkg::KIND_CHAR;
        char_item.res.text_char = shown_char;

        sum_item                 = '0;
        sum_item.kind            = ethp_pkg::KIND_SUMMARY;
        sum_item.res.dst_mac     = dst_mac_next;
        sum_item.res.src_mac     = src_mac_next;
        sum_item.res.frame_class = cls;
        if (cls != ethp_pkg::CLASS_OTHER) begin
            sum_item.res.src_ip = src_ip_next;
            sum_item.res.dst_ip = dst_ip_next;
        end
        if (cls == ethp_pkg::CLASS_TCP) begin
            sum_item.res.src_port    = src_port_next;
            sum_item.res.dst_port    = dst_port_next;
            sum_item.res.payload_len = plen;
        end

        push.count  = 2'd0;
        first_item  = sum_item;
        second_item = sum_item;
        if (in_fire) begin
            if (show) begin
                first_item = char_item;
                push.count = in_end ? 2'd2 : 2'd1;
            end else if (in_end) begin
                push.count = 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_fire && in_end)) begin
            off_reg        <= '0;
            dst_mac_reg    <= '0;
            src_mac_reg    <= '0;
            ether_type_reg <= '0;
            ihl_reg        <= '0;
            total_len_reg  <= '0;
            proto_reg      <= '0;
            src_ip_reg     <= '0;
            dst_ip_reg     <= '0;
            src_port_reg   <= '0;
            dst_port_reg   <= '0;
            doff_reg       <= '0;
            shown_reg      <= '0;
        end else if (in_fire) begin
            if (active) begin
                off_reg <= off_reg + 16'd1;
            end
            dst_mac_reg    <= dst_mac_next;
            src_mac_reg    <= src_mac_next;
            ether_type_reg <= ether_type_next;
            ihl_reg        <= ihl_next;
            total_len_reg  <= total_len_next;
            proto_reg      <= proto_next;
            src_ip_reg     <= src_ip_next;
            dst_ip_reg     <= dst_ip_next;
            src_port_reg   <= src_port_next;
            dst_port_reg   <= dst_port_next;
            doff_reg       <= doff_next;
            shown_reg      <= shown_next;
        end
    end

endmodule

>>> design/ethp_out_queue.sv
module ethp_out_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ethp_pkg::push_t        push,
    input  ethp_pkg::entry_t       first_item,
    input  ethp_pkg::entry_t       second_item,
    input  logic                   pop,
    output ethp_pkg::entry_t       head,
    output ethp_pkg::queue_status_t status
);

    ethp_pkg::entry_t mem [ethp_pkg::QUEUE_DEPTH];

    logic [ethp_pkg::QPTR_W-1:0] rd_ptr_reg, wr_ptr_reg;
    logic [ethp_pkg::QPTR_W-1:0] wr_ptr_inc;
    logic [ethp_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                        do_pop;

    assign wr_ptr_inc       = wr_ptr_reg + {{(ethp_pkg::QPTR_W-1){1'b0}}, 1'b1};
    assign status.not_empty = (count_reg != '0);
    assign status.room2     = (count_reg <= ethp_pkg::QCNT_W'(ethp_pkg::QUEUE_DEPTH - 2));
    assign do_pop           = pop && status.not_empty;
    assign head             = mem[rd_ptr_reg];
    assign count_next       = count_reg + {1'b0, push.count}
                            - {{(ethp_pkg::QCNT_W-1){1'b0}}, do_pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_reg + push.count;
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + {{(ethp_pkg::QPTR_W-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= first_item;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_inc] <= second_item;
        end
    end

endmodule

>>> design/eth_ipv4_tcp_header_parser_unit.sv
// Each result is registered into the result queue on the byte transfer that causes it.
// Throughput: one frame byte per cycle while s_tready is high; the per-byte parse is one
// level of logic between the header field registers and a four-entry result queue.
// A frame-end byte that also shows a character adds two results; s_tready drops while
// fewer than two queue slots are free.
// Reset: synchronous, active low; clears all frame state and the queue, max_shown to 200.
module eth_ipv4_tcp_header_parser_unit (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // frame_byte
    input  logic                             s_tlast,   // frame_end

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // text_char, dst_mac, src_mac, src_ip, dst_ip, src_port, dst_port, frame_class,
    // payload_len, zero fill
    output logic [ethp_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser,   // kind

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic [ethp_pkg::CFG_W-1:0] max_shown_reg;
    logic                       s_fire;
    logic                       m_fire;
    ethp_pkg::push_t            push;
    ethp_pkg::entry_t           first_item;
    ethp_pkg::entry_t           second_item;
    ethp_pkg::entry_t           head;
    ethp_pkg::queue_status_t    status;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == ethp_pkg::REG_MAX_SHOWN) ? {16'd0, max_shown_reg} : 32'd0;
    assign s_tready = status.room2;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = status.not_empty;
    assign m_fire   = m_tvalid && m_tready;
    assign m_tuser  = head.kind;
    assign m_tdata  = {{(ethp_pkg::M_TDATA_W - ethp_pkg::RES_W){1'b0}}, head.res};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_shown_reg <= ethp_pkg::MAX_SHOWN_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == ethp_pkg::REG_MAX_SHOWN) begin
            max_shown_reg <= pwdata[ethp_pkg::CFG_W-1:0];
        end
    end

    ethp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .max_shown   (max_shown_reg),
        .in_byte     (s_tdata),
        .in_end      (s_tlast),
        .in_fire     (s_fire),
        .push        (push),
        .first_item  (first_item),
        .second_item (second_item)
    );

    ethp_out_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .first_item  (first_item),
        .second_item (second_item),
        .pop         (m_fire),
        .head        (head),
        .status      (status)
    );

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result queue not empty after reset");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> m_tvalid)
        else $error("frame end transfer produced no summary");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (push.count == 2'd0))
        else $error("result pushed while input stalled");

    a_summary_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count == 2'd2) |-> (first_item.kind == ethp_pkg::KIND_CHAR
                                  && second_item.kind == ethp_pkg::KIND_SUMMARY))
        else $error("result order broken on frame end");
`endif

endmodule
